### hw/rtl/sorted_unique_value_table_top_assert.svh
// assertion macros for the sorted value table top level
// expects clk and rst_n in the scope of use
`ifndef SORTED_UNIQUE_VALUE_TABLE_TOP_ASSERT_SVH
`define SORTED_UNIQUE_VALUE_TABLE_TOP_ASSERT_SVH

// same-cycle implication, skipped during reset
`define SUVT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped during reset
`define SUVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/suvt_pkg.sv
// shared types for the sorted value table
// operation and status codes, controller command and status structs
package suvt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PUSH   = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_NOTBELOW = 3'd5
  } status_t;

  typedef struct packed {
    logic    load;
    logic    rd_cur;
    logic    rd_prev;
    logic    rd_next;
    logic    wr_data;
    logic    wr_value;
    logic    idx_inc;
    logic    idx_dec;
    logic    open_start;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    st_set;
    status_t st_code;
    logic    out_load;
  } suvt_cmd_t;

  typedef struct packed {
    op_t  op;
    logic idx_at_end;
    logic idx_at_pos;
    logic idx_last;
    logic cnt_zero;
    logic cnt_full;
    logic rd_less;
    logic rd_equal;
    logic out_free;
  } suvt_sts_t;

endpackage

### hw/rtl/sorted_unique_value_table_top.sv
// Sorted table of up to DEPTH distinct signed 32-bit values held in ascending order in an
// entry memory with one read and one write port. Each input transaction (insert, remove, push
// below smallest, pop smallest) yields one result transaction with a status code and the count
// held afterwards. One transaction is worked on at a time. Its length is set by the memory
// accesses: the scan reads and compares one entry at a time, and every entry moved to open or
// close a gap is first read and then written. Rejected full or empty cases, a duplicate insert
// (which stops where the scan finds the match) and a push not below the smallest end early;
// a finished result also waits while the previous result has not yet been taken by out_ready.
// The next transaction is taken while the previous result still waits. The memory needs no
// clearing after reset: only entries below the count are ever read. If DEPTH exceeds 127 the
// count field shows the count modulo 128.
// depends on suvt_pkg, suvt_ctrl, suvt_datapath and the assertion macro header
module sorted_unique_value_table_top import suvt_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [6:0]  out_count
);

  `include "sorted_unique_value_table_top_assert.svh"

  // command and status between the sequencer and the datapath
  suvt_cmd_t cmd;
  suvt_sts_t sts;

  // sequencer: scan, gap open, gap close, result hand-off
  suvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // entry memory, index and count registers, result register
  suvt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_op),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_count  (out_count)
  );

  // a taken transaction keeps the block busy for at least the next cycle
  `SUVT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  // a full report only comes with the full count
  `SUVT_ASSERT_IMPL(a_full_count, out_valid && out_status == ST_FULL, out_count == 7'(DEPTH), "full")
  // an empty report only comes with a zero count
  `SUVT_ASSERT_IMPL(a_empty_count, out_valid && out_status == ST_EMPTY, out_count == 7'd0, "empty")
  // a waiting result keeps its payload until taken
  `SUVT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_status) && $stable(out_count), "moved")

endmodule

### hw/rtl/suvt_datapath.sv
// datapath of the sorted value table: entry memory, index, count, result register
// depends on suvt_pkg
module suvt_datapath import suvt_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  suvt_cmd_t   cmd,
  output suvt_sts_t   sts,
  input  logic [1:0]  in_op,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [6:0]  out_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(DEPTH + 1);

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rd_data_r;
  logic signed [31:0] value_r;
  op_t                op_r;
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      pos_r;
  logic [IW-1:0]      count_r;
  status_t            st_r;
  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [6:0]         out_count_r;

  logic [IW-1:0] idx_prev;
  logic [IW-1:0] idx_next;
  logic [IW-1:0] rd_idx;
  logic          rd_en;

  assign idx_prev = idx_r - IW'(1);
  assign idx_next = idx_r + IW'(1);
  assign rd_en    = cmd.rd_cur | cmd.rd_prev | cmd.rd_next;

  always_comb begin
    rd_idx = idx_r;
    if (cmd.rd_prev) begin
      rd_idx = idx_prev;
    end else if (cmd.rd_next) begin
      rd_idx = idx_next;
    end
  end

  // single read and single write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx[AW-1:0]];
    end
    if (cmd.wr_data | cmd.wr_value) begin
      mem[idx_r[AW-1:0]] <= cmd.wr_value ? value_r : rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
      op_r    <= op_t'(in_op);
      idx_r   <= '0;
    end else if (cmd.open_start) begin
      pos_r <= idx_r;
      idx_r <= count_r;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_next;
    end else if (cmd.idx_dec) begin
      idx_r <= idx_prev;
    end
    if (cmd.st_set) begin
      st_r <= cmd.st_code;
    end
    if (cmd.out_load) begin
      out_status_r <= st_r;
      out_count_r  <= 7'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + IW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - IW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.idx_at_end = (idx_r == count_r);
    sts.idx_at_pos = (idx_r == pos_r);
    sts.idx_last   = (idx_next >= count_r);
    sts.cnt_zero   = (count_r == '0);
    sts.cnt_full   = (count_r == IW'(DEPTH));
    sts.rd_less    = ($signed(rd_data_r) < value_r);
    sts.rd_equal   = (rd_data_r == value_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule

### hw/rtl/suvt_ctrl.sv
// controller of the sorted value table: sequences scan, gap open and gap close
// depends on suvt_pkg
module suvt_ctrl import suvt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  suvt_sts_t sts,
  output suvt_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PUSH_CMP,
    S_OPEN_CHK,
    S_OPEN_WR,
    S_CLOSE_CHK,
    S_CLOSE_WR,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.st_code = ST_DONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        case (sts.op)
          OP_INSERT: begin
            if (sts.cnt_full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_FULL;
              state_nxt   = S_RESP;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          OP_REMOVE: begin
            if (sts.cnt_zero) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_EMPTY;
              state_nxt   = S_RESP;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          OP_PUSH: begin
            if (sts.cnt_full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_FULL;
              state_nxt   = S_RESP;
            end else if (sts.cnt_zero) begin
              cmd.open_start = 1'b1;
              state_nxt      = S_OPEN_CHK;
            end else begin
              cmd.rd_cur = 1'b1;
              state_nxt  = S_PUSH_CMP;
            end
          end
          default: begin
            if (sts.cnt_zero) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_EMPTY;
              state_nxt   = S_RESP;
            end else begin
              state_nxt = S_CLOSE_CHK;
            end
          end
        endcase
      end
      S_SCAN_RD: begin
        if (sts.idx_at_end) begin
          if (sts.op == OP_INSERT) begin
            cmd.open_start = 1'b1;
            state_nxt      = S_OPEN_CHK;
          end else begin
            cmd.st_set  = 1'b1;
            cmd.st_code = ST_NOTFOUND;
            state_nxt   = S_RESP;
          end
        end else begin
          cmd.rd_cur = 1'b1;
          state_nxt  = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts.rd_less) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end else if (sts.rd_equal) begin
          if (sts.op == OP_INSERT) begin
            cmd.st_set  = 1'b1;
            cmd.st_code = ST_DUP;
            state_nxt   = S_RESP;
          end else begin
            state_nxt = S_CLOSE_CHK;
          end
        end else begin
          if (sts.op == OP_INSERT) begin
            cmd.open_start = 1'b1;
            state_nxt      = S_OPEN_CHK;
          end else begin
            cmd.st_set  = 1'b1;
            cmd.st_code = ST_NOTFOUND;
            state_nxt   = S_RESP;
          end
        end
      end
      S_PUSH_CMP: begin
        // equal to the smallest counts as not below
        if (sts.rd_less || sts.rd_equal) begin
          cmd.st_set  = 1'b1;
          cmd.st_code = ST_NOTBELOW;
          state_nxt   = S_RESP;
        end else begin
          cmd.open_start = 1'b1;
          state_nxt      = S_OPEN_CHK;
        end
      end
      S_OPEN_CHK: begin
        if (sts.idx_at_pos) begin
          cmd.wr_value = 1'b1;
          cmd.cnt_inc  = 1'b1;
          cmd.st_set   = 1'b1;
          cmd.st_code  = ST_DONE;
          state_nxt    = S_RESP;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_OPEN_WR;
        end
      end
      S_OPEN_WR: begin
        cmd.wr_data = 1'b1;
        cmd.idx_dec = 1'b1;
        state_nxt   = S_OPEN_CHK;
      end
      S_CLOSE_CHK: begin
        if (sts.idx_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.st_set  = 1'b1;
          cmd.st_code = ST_DONE;
          state_nxt   = S_RESP;
        end else begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_CLOSE_WR;
        end
      end
      S_CLOSE_WR: begin
        cmd.wr_data = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_CLOSE_CHK;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
